// ===== sv/utf8_validate_repair_defines.svh =====
// Assertion macros shared by the UTF-8 validator checker.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef UTF8_VALIDATE_REPAIR_DEFINES_SVH
`define UTF8_VALIDATE_REPAIR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8V_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTF8V_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/utf8v_pkg.sv =====
// Package of the UTF-8 validator: payload and group types and byte constants.
// Depends on nothing; used by every module of the block.
package utf8v_pkg;

  localparam int unsigned GROUP_DEPTH = 4;
  localparam int unsigned GROUP_PTR_W = $clog2(GROUP_DEPTH);

  localparam logic [7:0] REPAIR_CHAR  = 8'h3F;
  localparam logic [7:0] LEAD_MIN     = 8'hC2;
  localparam logic [7:0] LEAD_MAX     = 8'hF4;
  localparam logic [7:0] LEAD_3B      = 8'hE0;
  localparam logic [7:0] LEAD_4B      = 8'hF0;
  localparam logic [7:0] LEAD_SURR    = 8'hED;
  localparam logic [7:0] LEAD_NONCHAR = 8'hEF;
  localparam logic [7:0] MID_NONCHAR  = 8'hBF;
  localparam logic [7:0] LAST_NONCHAR = 8'hBE;
  localparam logic [7:0] TRAIL_MIN    = 8'h80;
  localparam logic [7:0] TRAIL_MAX    = 8'hBF;
  localparam logic [7:0] E0_TRAIL_MIN = 8'hA0;
  localparam logic [7:0] ED_TRAIL_MAX = 8'h9F;
  localparam logic [7:0] F0_TRAIL_MIN = 8'h90;
  localparam logic [7:0] F4_TRAIL_MAX = 8'h8F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } utf8v_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_bad;
    logic        out_last;
    logic        stream_valid;
    logic [31:0] error_pos;
  } utf8v_out_t;

  // All results caused by one request: held bytes first, then the current byte.
  typedef struct packed {
    logic [2:0][7:0] pend;
    logic [7:0]      cur;
    logic [1:0]      pend_cnt;
    logic            pend_bad;
    logic            cur_emit;
    logic            cur_bad;
    logic            last;
    logic            stream_ok;
    logic [31:0]     err_pos;
  } utf8v_group_t;

endpackage

// ===== sv/utf8v_front.sv =====
// Front end of the UTF-8 validator: sequence state and per-request classification.
// Depends on utf8v_pkg.
module utf8v_front #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  utf8v_pkg::utf8v_in_t   in_i,
  output utf8v_pkg::utf8v_group_t grp_o,
  output logic                   grp_valid_o
);
  import utf8v_pkg::*;

  logic [2:0][7:0]       pend_q, pend_d;
  logic [1:0]            pc_q, pc_d;
  logic [1:0]            et_q, et_d;
  logic [POS_WIDTH-1:0]  pos_q;
  logic [POS_WIDTH-1:0]  seq_q, seq_d;
  logic [POS_WIDTH-1:0]  first_q;
  logic                  err_q;

  logic [7:0]            b;
  logic                  last;
  logic                  is_ascii, is_lead, in_rng, nonchar, take;
  logic [1:0]            lead_trail;
  logic [7:0]            lo, hi;
  logic                  err_now, err_any;
  logic [POS_WIDTH-1:0]  err_at, err_pos_n;
  logic [POS_WIDTH+31:0] err_ext;
  logic [1:0]            pend_cnt;
  logic                  pend_bad, cur_emit, cur_bad;

  assign b        = in_i.in_byte;
  assign last     = in_i.in_last;
  assign is_ascii = !b[7];
  assign is_lead  = (b >= LEAD_MIN) && (b <= LEAD_MAX);
  assign lead_trail = (b >= LEAD_4B) ? 2'd3 : ((b >= LEAD_3B) ? 2'd2 : 2'd1);

  always_comb begin
    lo = TRAIL_MIN;
    hi = TRAIL_MAX;
    if (pc_q == 2'd1) begin
      unique case (pend_q[0])
        LEAD_3B:   lo = E0_TRAIL_MIN;
        LEAD_SURR: hi = ED_TRAIL_MAX;
        LEAD_4B:   lo = F0_TRAIL_MIN;
        LEAD_MAX:  hi = F4_TRAIL_MAX;
        default: ;
      endcase
    end
  end

  assign in_rng  = (b >= lo) && (b <= hi);
  assign nonchar = (pc_q == 2'd2) && (et_q == 2'd2) && (pend_q[0] == LEAD_NONCHAR) &&
                   (pend_q[1] == MID_NONCHAR) && (b >= LAST_NONCHAR);

  always_comb begin
    pend_cnt = 2'd0;
    pend_bad = 1'b0;
    cur_emit = 1'b0;
    cur_bad  = 1'b0;
    err_now  = 1'b0;
    err_at   = seq_q;
    take     = 1'b0;
    pc_d     = 2'd0;
    et_d     = 2'd0;
    seq_d    = seq_q;
    pend_d   = pend_q;
    if (pc_q == 2'd0) begin
      take   = 1'b1;
      err_at = pos_q;
    end else if (in_rng) begin
      if (nonchar) begin
        pend_cnt = pc_q;
        pend_bad = 1'b1;
        cur_emit = 1'b1;
        cur_bad  = 1'b1;
        err_now  = 1'b1;
      end else if (pc_q >= et_q) begin
        pend_cnt = pc_q;
        cur_emit = 1'b1;
      end else begin
        pend_d[pc_q] = b;
        pc_d         = pc_q + 2'd1;
        et_d         = et_q;
        if (last) begin
          pend_cnt = pc_q;
          pend_bad = 1'b1;
          cur_emit = 1'b1;
          cur_bad  = 1'b1;
          err_now  = 1'b1;
          pc_d     = 2'd0;
        end
      end
    end else begin
      pend_cnt = pc_q;
      pend_bad = 1'b1;
      err_now  = 1'b1;
      take     = 1'b1;
    end
    if (take) begin
      if (is_ascii) begin
        cur_emit = 1'b1;
      end else if (is_lead && !last) begin
        pend_d[0] = b;
        pc_d      = 2'd1;
        et_d      = lead_trail;
        seq_d     = pos_q;
      end else begin
        cur_emit = 1'b1;
        cur_bad  = 1'b1;
        err_now  = 1'b1;
      end
    end
  end

  assign err_any   = err_q || err_now;
  assign err_pos_n = err_q ? first_q : err_at;
  assign err_ext   = {32'd0, err_pos_n};

  always_comb begin
    grp_o.pend      = pend_q;
    grp_o.cur       = b;
    grp_o.pend_cnt  = pend_cnt;
    grp_o.pend_bad  = pend_bad;
    grp_o.cur_emit  = cur_emit;
    grp_o.cur_bad   = cur_bad;
    grp_o.last      = last;
    grp_o.stream_ok = last && !err_any;
    grp_o.err_pos   = (last && err_any) ? err_ext[31:0] : 32'd0;
  end

  assign grp_valid_o = accept_i && ((pend_cnt != 2'd0) || cur_emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= 2'd0;
      et_q    <= 2'd0;
      pos_q   <= '0;
      seq_q   <= '0;
      first_q <= '0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      if (last) begin
        pc_q    <= 2'd0;
        et_q    <= 2'd0;
        pos_q   <= '0;
        seq_q   <= '0;
        first_q <= '0;
        err_q   <= 1'b0;
      end else begin
        pc_q    <= pc_d;
        et_q    <= et_d;
        pos_q   <= pos_q + {{(POS_WIDTH-1){1'b0}}, 1'b1};
        seq_q   <= seq_d;
        first_q <= err_pos_n;
        err_q   <= err_any;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

// ===== sv/utf8v_queue.sv =====
// Short queue of result groups between the front and back ends of the validator.
// Depends on utf8v_pkg.
module utf8v_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_i,
  input  utf8v_pkg::utf8v_group_t wr_grp_i,
  input  logic                    rd_i,
  output utf8v_pkg::utf8v_group_t rd_grp_o,
  output logic                    empty_o,
  output logic                    full_o
);
  import utf8v_pkg::*;

  utf8v_group_t           mem_q [GROUP_DEPTH];
  logic [GROUP_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [GROUP_PTR_W:0]   cnt_q;

  assign empty_o  = (cnt_q == '0);
  assign full_o   = (cnt_q == (GROUP_PTR_W+1)'(GROUP_DEPTH));
  assign rd_grp_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + {{(GROUP_PTR_W-1){1'b0}}, 1'b1};
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + {{(GROUP_PTR_W-1){1'b0}}, 1'b1};
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + {{GROUP_PTR_W{1'b0}}, 1'b1};
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - {{GROUP_PTR_W{1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_grp_i;
    end
  end

endmodule

// ===== sv/utf8v_back.sv =====
// Back end of the UTF-8 validator: hands out the bytes of each queued group in order.
// Depends on utf8v_pkg.
module utf8v_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  utf8v_pkg::utf8v_group_t grp_i,
  input  logic                    grp_empty_i,
  input  logic                    repair_i,
  input  logic                    pop_i,
  output logic                    empty_o,
  output utf8v_pkg::utf8v_out_t   out_o,
  output logic                    grp_rd_o
);
  import utf8v_pkg::*;

  logic [1:0] idx_q;
  logic [2:0] n_items;
  logic       final_item;
  logic       from_pend;
  logic [7:0] raw_byte;
  logic       bad;

  assign n_items    = {1'b0, grp_i.pend_cnt} + {2'b00, grp_i.cur_emit};
  assign final_item = ({1'b0, idx_q} == (n_items - 3'd1));
  assign from_pend  = (idx_q < grp_i.pend_cnt);
  assign raw_byte   = from_pend ? grp_i.pend[idx_q] : grp_i.cur;
  assign bad        = from_pend ? grp_i.pend_bad : grp_i.cur_bad;

  assign empty_o  = grp_empty_i;
  assign grp_rd_o = pop_i && !grp_empty_i && final_item;

  always_comb begin
    out_o.out_byte     = (bad && repair_i) ? REPAIR_CHAR : raw_byte;
    out_o.out_bad      = bad;
    out_o.out_last     = grp_i.last && final_item;
    out_o.stream_valid = grp_i.stream_ok && final_item;
    out_o.error_pos    = final_item ? grp_i.err_pos : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (pop_i && !grp_empty_i) begin
      idx_q <= final_item ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// ===== sv/utf8_validate_repair.sv =====
// Top level of the UTF-8 stream validator with optional repair.
// Depends on utf8v_pkg, utf8v_front, utf8v_queue and utf8v_back.
//
// Usage: bytes enter on the input queue port (push, full, in_i) with in_last
// on the final byte of a stream. Result bytes leave on the output queue port
// (empty, pop, out_o); a byte appears once its UTF-8 sequence is decided, so
// one request gives zero to four results. out_last, stream_valid and
// error_pos are set on the final result of a stream.
// Results of a taken request are registered in the group queue before out_o.
// Throughput: one request per cycle while the group queue has room; the
// output port hands out one result per cycle while pop is high, so the
// results of a request that releases a whole held sequence leave in turn.
// Reset clears the sequence state, the queue and the offsets, and sets
// repair mode. A stalled receiver fills the four-group queue, after which
// full rises until results are popped. cfg_we_i/cfg_wdata_i write the repair
// enable. Use them only while the block is idle; it is not enforced.
module utf8_validate_repair #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  utf8v_pkg::utf8v_in_t  in_i,
  output logic                  empty,
  input  logic                  pop,
  output utf8v_pkg::utf8v_out_t out_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i
);
  import utf8v_pkg::*;

  logic         repair_q;
  logic         accept;
  utf8v_group_t front_grp, head_grp;
  logic         front_wr, q_empty, q_rd;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repair_q <= 1'b1;
    end else if (cfg_we_i) begin
      repair_q <= cfg_wdata_i;
    end
  end

  utf8v_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_i),
    .grp_o      (front_grp),
    .grp_valid_o(front_wr)
  );

  utf8v_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (front_wr),
    .wr_grp_i(front_grp),
    .rd_i    (q_rd),
    .rd_grp_o(head_grp),
    .empty_o (q_empty),
    .full_o  (full)
  );

  utf8v_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_i      (head_grp),
    .grp_empty_i(q_empty),
    .repair_i   (repair_q),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_o      (out_o),
    .grp_rd_o   (q_rd)
  );

endmodule

// ===== sv/utf8v_checker.sv =====
// Port-level checker for the UTF-8 validator and its bind to the top level.
// Depends on utf8v_pkg and utf8_validate_repair_defines.svh.
`include "utf8_validate_repair_defines.svh"

module utf8v_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input utf8v_pkg::utf8v_out_t out_o
);
  import utf8v_pkg::*;

  `UTF8V_ASSERT_NEXT(a_stall_hold, !empty && !pop, !empty && $stable(out_o), "Waiting result changed while stalled")
  `UTF8V_ASSERT_SAME(a_valid_on_last, !empty && out_o.stream_valid, out_o.out_last, "Stream validity shown before the last result")
  `UTF8V_ASSERT_SAME(a_pos_on_error, !empty && (out_o.error_pos != 32'd0), out_o.out_last && !out_o.stream_valid, "Error position shown without a failed stream end")
  `UTF8V_ASSERT_SAME(a_bad_not_valid, !empty && out_o.out_bad, !out_o.stream_valid, "Stream reported valid on a bad byte")

endmodule

bind utf8_validate_repair utf8v_checker u_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .empty (empty),
  .pop   (pop),
  .out_o (out_o)
);

// ===== tb/sv/utf8_validate_repair_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the UTF-8 stream validator with optional repair.
// Depends on utf8v_pkg and utf8_validate_repair; predicts every result byte
// and checks it in order.
module utf8_validate_repair_tb;
  import utf8v_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  utf8v_in_t  in_i;
  logic       empty;
  logic       pop = 1'b0;
  utf8v_out_t out_o;
  logic       cfg_we;
  logic       cfg_wdata;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  logic        repair_mode;
  logic [7:0]  held [3];
  int unsigned held_cnt;
  int unsigned need_trail;
  logic [31:0] next_pos;
  logic [31:0] lead_pos;
  logic [31:0] first_err_pos;
  logic        err_seen;
  utf8v_out_t  step_q [$];
  utf8v_out_t  expected_bytes_q [$];
  utf8v_out_t  want;

  utf8_validate_repair dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_stream();
    held[0] = '0;
    held[1] = '0;
    held[2] = '0;
    held_cnt = 0;
    need_trail = 0;
    next_pos = '0;
    lead_pos = '0;
    first_err_pos = '0;
    err_seen = 1'b0;
  endfunction

  function automatic void release_byte(logic [7:0] b, logic bad);
    utf8v_out_t r;
    r = '0;
    r.out_byte = (bad && repair_mode) ? REPAIR_CHAR : b;
    r.out_bad = bad;
    step_q.push_back(r);
  endfunction

  function automatic void note_error(logic [31:0] pos);
    if (!err_seen) begin
      err_seen = 1'b1;
      first_err_pos = pos;
    end
  endfunction

  function automatic void flush_held(logic bad);
    for (int unsigned i = 0; i < held_cnt; i++) release_byte(held[i], bad);
    held_cnt = 0;
    need_trail = 0;
  endfunction

  function automatic void take_lead(logic [7:0] b, logic [31:0] pos);
    if (b < TRAIL_MIN) begin
      release_byte(b, 1'b0);
    end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
      need_trail = (b >= LEAD_4B) ? 3 : ((b >= LEAD_3B) ? 2 : 1);
      held[0] = b;
      held_cnt = 1;
      lead_pos = pos;
    end else begin
      note_error(pos);
      release_byte(b, 1'b1);
    end
  endfunction

  function automatic void predict_utf8(logic [7:0] b, logic is_last);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [31:0] pos;
    int          k;
    step_q.delete();
    pos = next_pos;
    if (held_cnt == 0) begin
      take_lead(b, pos);
    end else begin
      lo = TRAIL_MIN;
      hi = TRAIL_MAX;
      if (held_cnt == 1) begin
        case (held[0])
          LEAD_3B:   lo = E0_TRAIL_MIN;
          LEAD_SURR: hi = ED_TRAIL_MAX;
          LEAD_4B:   lo = F0_TRAIL_MIN;
          LEAD_MAX:  hi = F4_TRAIL_MAX;
          default: ;
        endcase
      end
      if (b >= lo && b <= hi) begin
        if (held_cnt == 2 && need_trail == 2 && held[0] == LEAD_NONCHAR &&
            held[1] == MID_NONCHAR && b >= LAST_NONCHAR) begin
          note_error(lead_pos);
          flush_held(1'b1);
          release_byte(b, 1'b1);
        end else if (held_cnt >= need_trail) begin
          flush_held(1'b0);
          release_byte(b, 1'b0);
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end else begin
        note_error(lead_pos);
        flush_held(1'b1);
        take_lead(b, pos);
      end
    end
    if (is_last && held_cnt > 0) begin
      note_error(lead_pos);
      flush_held(1'b1);
    end
    next_pos = pos + 1;
    if (is_last) begin
      k = step_q.size() - 1;
      if (k >= 0) begin
        step_q[k].out_last = 1'b1;
        step_q[k].stream_valid = !err_seen;
        step_q[k].error_pos = err_seen ? first_err_pos : '0;
      end
      clear_stream();
    end
    foreach (step_q[i]) expected_bytes_q.push_back(step_q[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_i <= '{in_byte: b, in_last: is_last};
    do @(posedge clk); while (full);
    predict_utf8(b, is_last);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_repair(input logic value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    repair_mode = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_valid_sequences();
    send_byte(8'h00, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_illegal_bytes();
    send_byte(8'h80, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b1);
  endtask

  task automatic test_truncated_streams();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    logic [7:0]  seq [4];
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(99);
      len = $urandom_range(1, 4);
      if (kind < 50) begin
        seq[1] = 8'($urandom_range(TRAIL_MIN, TRAIL_MAX));
        seq[2] = 8'($urandom_range(TRAIL_MIN, TRAIL_MAX));
        seq[3] = 8'($urandom_range(TRAIL_MIN, TRAIL_MAX));
        case (len)
          1: seq[0] = 8'($urandom_range(0, TRAIL_MIN - 1));
          2: seq[0] = 8'($urandom_range(LEAD_MIN, LEAD_3B - 1));
          3: begin
            seq[0] = 8'($urandom_range(LEAD_3B, LEAD_4B - 1));
            if (seq[0] == LEAD_3B) seq[1] = 8'($urandom_range(E0_TRAIL_MIN, TRAIL_MAX));
            else if (seq[0] == LEAD_SURR) seq[1] = 8'($urandom_range(TRAIL_MIN, ED_TRAIL_MAX));
            else if (seq[0] == LEAD_NONCHAR && seq[1] == MID_NONCHAR)
              seq[2] = 8'($urandom_range(TRAIL_MIN, LAST_NONCHAR - 1));
          end
          default: begin
            seq[0] = 8'($urandom_range(LEAD_4B, LEAD_MAX));
            if (seq[0] == LEAD_4B) seq[1] = 8'($urandom_range(F0_TRAIL_MIN, TRAIL_MAX));
            else if (seq[0] == LEAD_MAX) seq[1] = 8'($urandom_range(TRAIL_MIN, F4_TRAIL_MAX));
          end
        endcase
      end else if (kind < 80) begin
        case ($urandom_range(9))
          0: seq[0] = 8'hC0;
          1: seq[0] = 8'hC1;
          2: seq[0] = LEAD_MIN;
          3: seq[0] = 8'hDF;
          4: seq[0] = LEAD_3B;
          5: seq[0] = LEAD_SURR;
          6: seq[0] = LEAD_NONCHAR;
          7: seq[0] = LEAD_4B;
          8: seq[0] = LEAD_MAX;
          default: seq[0] = 8'hF5;
        endcase
        for (int i = 1; i < 4; i++) begin
          case ($urandom_range(8))
            0: seq[i] = 8'h7F;
            1: seq[i] = TRAIL_MIN;
            2: seq[i] = F4_TRAIL_MAX;
            3: seq[i] = F0_TRAIL_MIN;
            4: seq[i] = ED_TRAIL_MAX;
            5: seq[i] = E0_TRAIL_MIN;
            6: seq[i] = LAST_NONCHAR;
            7: seq[i] = TRAIL_MAX;
            default: seq[i] = 8'hC0;
          endcase
        end
      end else begin
        len = 1;
        seq[0] = 8'($urandom_range(255));
      end
      for (int unsigned i = 0; i < len; i++) begin
        send_byte(seq[i], $urandom_range(19) == 0);
        sent++;
      end
    end
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  always @(posedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_bytes_q.size() == 0) begin
        $display("%0t: result byte %h with no request waiting", $time, out_o.out_byte);
        mismatch_cnt++;
      end else begin
        want = expected_bytes_q.pop_front();
        if (out_o !== want) begin
          $display("%0t: expected byte %h bad %b last %b valid %b pos %h, got byte %h bad %b last %b valid %b pos %h",
                   $time, want.out_byte, want.out_bad, want.out_last, want.stream_valid,
                   want.error_pos, out_o.out_byte, out_o.out_bad, out_o.out_last,
                   out_o.stream_valid, out_o.error_pos);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_bytes_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    push <= 1'b0;
    in_i <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    rst_n <= 1'b0;
    clear_stream();
    repair_mode = 1'b1;
    send_idle_pct = 34;
    recv_idle_pct = 49;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_valid_sequences();
    test_illegal_bytes();
    test_truncated_streams();
    wait_drained();
    write_repair(1'b0);
    test_random_traffic(85);

    wait_drained();
    send_idle_pct = 49;
    recv_idle_pct = 34;
    write_repair(1'b1);
    test_random_traffic(85);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_repair(1'b0);
    test_random_traffic(80);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
